// File: design/e2q_pkg.sv
`default_nettype none
package e2q_pkg;
    localparam int FRAC = 30;
    localparam int STEPS = 30;
    localparam int CW = 34;
    localparam int ZW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q = 34'sd3373259426;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    typedef struct packed {
        cval_t c;
        cval_t s;
    } sc_t;

    function automatic zval_t atan_lut(input logic [4:0] i);
        zval_t r;
        r = '0;
        case (i)
            5'd0: r = 34'sd843314856;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043836;
            5'd3: r = 34'sd133525158;
            5'd4: r = 34'sd67021686;
            5'd5: r = 34'sd33543515;
            5'd6: r = 34'sd16775850;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194282;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            5'd24: r = 34'sd63;
            5'd25: r = 34'sd31;
            5'd26: r = 34'sd15;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q2.30 product rounded half up.
    function automatic cval_t qmul(input cval_t a, input cval_t b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< (FRAC - 1));
        return cval_t'(p >>> FRAC);
    endfunction
endpackage
`default_nettype wire

// File: design/e2q_cordic.sv
`default_nettype none
// Pipelined rotation-mode CORDIC: one stage per iteration, plus a fold stage.
module e2q_cordic #(
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [ANGLE_WIDTH-1:0] angle,
    output e2q_pkg::sc_t                       result
);
    localparam int N = e2q_pkg::STEPS;

    e2q_pkg::cval_t x_reg [N+1];
    e2q_pkg::cval_t y_reg [N+1];
    e2q_pkg::zval_t z_reg [N+1];
    logic           neg_reg [N+1];
    e2q_pkg::zval_t z_in;
    e2q_pkg::zval_t z_next;
    logic           neg_next;

    // Sign-extend to Q2.30, Q3.(W-3) scaled to the half angle.
    always_comb
    begin
        z_in = e2q_pkg::zval_t'(angle) <<< (32 - ANGLE_WIDTH);
        z_next = z_in;
        neg_next = 1'b0;
        if (z_in > e2q_pkg::HALF_PI)
        begin
            z_next = z_in - e2q_pkg::PI_Q;
            neg_next = 1'b1;
        end
        else if (z_in < -e2q_pkg::HALF_PI)
        begin
            z_next = z_in + e2q_pkg::PI_Q;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= e2q_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][e2q_pkg::ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - e2q_pkg::atan_lut(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + e2q_pkg::atan_lut(5'(i));
                end
            end
        end
    end

    assign result.c = neg_reg[N] ? -x_reg[N] : x_reg[N];
    assign result.s = neg_reg[N] ? -y_reg[N] : y_reg[N];
endmodule
`default_nettype wire

// File: design/e2q_combine.sv
`default_nettype none
// Quaternion product stages: pair products, triple products, sums, output rounding.
module e2q_combine #(
    parameter int QUAT_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire e2q_pkg::sc_t                 r,
    input  wire e2q_pkg::sc_t                 p,
    input  wire e2q_pkg::sc_t                 y,
    output logic signed [QUAT_WIDTH-1:0]      qw,
    output logic signed [QUAT_WIDTH-1:0]      qx,
    output logic signed [QUAT_WIDTH-1:0]      qy,
    output logic signed [QUAT_WIDTH-1:0]      qz
);
    localparam int SH = 32 - QUAT_WIDTH;
    localparam int OW = e2q_pkg::CW + 2;
    typedef logic signed [OW-1:0] wide_t;
    localparam wide_t ONE = wide_t'(1) <<< (QUAT_WIDTH - 2);

    e2q_pkg::cval_t crcp_reg, srsp_reg, crsp_reg, srcp_reg, cy_reg, sy_reg;
    e2q_pkg::cval_t t_reg [8];
    wide_t          v_reg [4];

    function automatic logic signed [QUAT_WIDTH-1:0] to_out(input wide_t v);
        wide_t t;
        t = v;
        if (SH > 0)
            t = (v + (wide_t'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        if (t > ONE)
            t = ONE;
        if (t < -ONE)
            t = -ONE;
        return t[QUAT_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= e2q_pkg::qmul(r.c, p.c);
            srsp_reg <= e2q_pkg::qmul(r.s, p.s);
            crsp_reg <= e2q_pkg::qmul(r.c, p.s);
            srcp_reg <= e2q_pkg::qmul(r.s, p.c);
            cy_reg   <= y.c;
            sy_reg   <= y.s;
            t_reg[0] <= e2q_pkg::qmul(crcp_reg, cy_reg);
            t_reg[1] <= e2q_pkg::qmul(srsp_reg, sy_reg);
            t_reg[2] <= e2q_pkg::qmul(srcp_reg, cy_reg);
            t_reg[3] <= e2q_pkg::qmul(crsp_reg, sy_reg);
            t_reg[4] <= e2q_pkg::qmul(crsp_reg, cy_reg);
            t_reg[5] <= e2q_pkg::qmul(srcp_reg, sy_reg);
            t_reg[6] <= e2q_pkg::qmul(crcp_reg, sy_reg);
            t_reg[7] <= e2q_pkg::qmul(srsp_reg, cy_reg);
            v_reg[0] <= wide_t'(t_reg[0]) + wide_t'(t_reg[1]);
            v_reg[1] <= wide_t'(t_reg[2]) - wide_t'(t_reg[3]);
            v_reg[2] <= wide_t'(t_reg[4]) + wide_t'(t_reg[5]);
            v_reg[3] <= wide_t'(t_reg[6]) - wide_t'(t_reg[7]);
        end
    end

    assign qw = to_out(v_reg[0]);
    assign qx = to_out(v_reg[1]);
    assign qy = to_out(v_reg[2]);
    assign qz = to_out(v_reg[3]);
endmodule
`default_nettype wire

// File: design/euler_to_quaternion_unit.sv
`default_nettype none
// Euler roll, pitch and yaw (Q3.(ANGLE_WIDTH-3) radians) to a unit quaternion in
// Q1.(QUAT_WIDTH-2), ZYX order, each part rounded and saturated to plus or minus one.
// The pipeline takes one transaction per clock and is 34 register stages deep:
// a fold stage and 30 CORDIC iteration stages per angle, then pair products,
// triple products and sums. The whole pipeline advances when the output
// register is empty or being read, so a stall holds every stage in place.
module euler_to_quaternion_unit #(
    parameter int ANGLE_WIDTH = 16,
    parameter int QUAT_WIDTH  = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle from bit 0 up
    input  wire logic [3*ANGLE_WIDTH-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up
    output logic [4*QUAT_WIDTH-1:0]        m_axis_tdata
);
    localparam int DEPTH = e2q_pkg::STEPS + 1 + 3;

    logic              en;
    logic [DEPTH-1:0]  vld_reg;
    e2q_pkg::sc_t      sc_r, sc_p, sc_y;
    logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;

    // The last valid bit marks the output register.
    assign en = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[ANGLE_WIDTH-1:0]), .result(sc_r));
    e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]), .result(sc_p));
    e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]), .result(sc_y));

    e2q_combine #(.QUAT_WIDTH(QUAT_WIDTH)) u_comb (
        .clk(clk), .en(en), .r(sc_r), .p(sc_p), .y(sc_y),
        .qw(qw), .qx(qx), .qy(qy), .qz(qz));

    assign m_axis_tdata = {qz, qy, qx, qw};
endmodule
`default_nettype wire

// File: design/e2q_checker.sv
`default_nettype none
module e2q_checker #(
    parameter int QUAT_WIDTH = 16
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    s_axis_tready,
    input wire logic                    m_axis_tvalid,
    input wire logic                    m_axis_tready,
    input wire logic [4*QUAT_WIDTH-1:0] m_axis_tdata
);
    localparam logic signed [QUAT_WIDTH-1:0] ONE = QUAT_WIDTH'(1) <<< (QUAT_WIDTH - 2);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[QUAT_WIDTH-1:0]) <= ONE
            && $signed(m_axis_tdata[QUAT_WIDTH-1:0]) >= -ONE)
        else $error("quat_w beyond one");
endmodule

bind euler_to_quaternion_unit e2q_checker #(.QUAT_WIDTH(QUAT_WIDTH)) u_e2q_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire

// File: test/euler_to_quaternion_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// Streams roll/pitch/yaw angle triples into the Euler-to-quaternion pipeline
// and checks every quaternion that comes out against a bit-exact predictor.
module euler_to_quaternion_unit_tb;
    localparam int AW = 16;
    localparam int QW = 16;
    localparam int QONE = 1 << (QW - 2);
    localparam int ANGLE_MAX = 25736;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] w;
    } quat_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // roll_angle, pitch_angle, yaw_angle from bit 0 up
    logic [3*AW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // quat_w, quat_x, quat_y, quat_z from bit 0 up
    logic [4*QW-1:0] m_axis_tdata;

    quat_t expected_quats[$];
    int errors = 0;
    int quats_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct;
    int recv_idle_pct;

    euler_to_quaternion_unit #(.ANGLE_WIDTH(AW), .QUAT_WIDTH(QW)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Half-angle sine and cosine: the Q3.13 angle reads directly as a Q2.30
    // half angle after a left shift, folded into the CORDIC range.
    function automatic void half_sincos(input logic [AW-1:0] ang,
                                        output longint c, output longint s);
        longint zz;
        longint xx;
        longint yy;
        longint t;
        bit flip;
        zz = longint'(signed'(ang)) <<< (32 - AW);
        xx = 64'sd652032874;
        yy = 0;
        flip = 1'b0;
        if (zz > 64'sd1686629713)
        begin
            zz = zz - 64'sd3373259426;
            flip = 1'b1;
        end
        else if (zz < -64'sd1686629713)
        begin
            zz = zz + 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < e2q_pkg::STEPS; i++)
        begin
            if (zz >= 0)
            begin
                t = xx - (yy >>> i);
                yy = yy + (xx >>> i);
                zz = zz - longint'(e2q_pkg::atan_lut(i[4:0]));
            end
            else
            begin
                t = xx + (yy >>> i);
                yy = yy - (xx >>> i);
                zz = zz + longint'(e2q_pkg::atan_lut(i[4:0]));
            end
            xx = t;
        end
        c = flip ? -xx : xx;
        s = flip ? -yy : yy;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [QW-1:0] round_sat(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (32 - QW - 1))) >>> (32 - QW);
        if (r > QONE) r = QONE;
        if (r < -QONE) r = -QONE;
        return r[QW-1:0];
    endfunction

    function automatic quat_t euler_to_quat(input logic [3*AW-1:0] angles);
        longint cr, sr, cp, sp, cy, sy;
        longint crcp, srsp, crsp, srcp;
        quat_t q;
        half_sincos(angles[AW-1:0], cr, sr);
        half_sincos(angles[2*AW-1:AW], cp, sp);
        half_sincos(angles[3*AW-1:2*AW], cy, sy);
        crcp = mul_q30(cr, cp);
        srsp = mul_q30(sr, sp);
        crsp = mul_q30(cr, sp);
        srcp = mul_q30(sr, cp);
        q.w = round_sat(mul_q30(crcp, cy) + mul_q30(srsp, sy));
        q.x = round_sat(mul_q30(srcp, cy) - mul_q30(crsp, sy));
        q.y = round_sat(mul_q30(crsp, cy) + mul_q30(srcp, sy));
        q.z = round_sat(mul_q30(crcp, sy) - mul_q30(srsp, cy));
        return q;
    endfunction

    // Sends one angle triple, with a random gap before it, and records the
    // quaternion it must produce once the transaction is accepted. Valid stays
    // high after acceptance so the next triple can follow in the next cycle.
    task automatic send_angles(input logic [AW-1:0] roll, input logic [AW-1:0] pitch,
                               input logic [AW-1:0] yaw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {yaw, pitch, roll};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_quats.push_back(euler_to_quat({yaw, pitch, roll}));
    endtask

    function automatic logic [AW-1:0] rand_angle();
        return AW'($signed($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
    endfunction

    // Field extremes, the full raw field range beyond pi, and the fold edges.
    task automatic test_directed();
        send_angles(16'd0, 16'd0, 16'd0);
        send_angles(16'(ANGLE_MAX), 16'd0, 16'd0);
        send_angles(16'd0, 16'(-ANGLE_MAX), 16'd0);
        send_angles(16'd0, 16'd0, 16'(ANGLE_MAX));
        send_angles(16'(-ANGLE_MAX), 16'(-ANGLE_MAX), 16'(-ANGLE_MAX));
        send_angles(16'(ANGLE_MAX), 16'(ANGLE_MAX), 16'(ANGLE_MAX));
        send_angles(16'h7fff, 16'h8000, 16'h7fff);
        send_angles(16'h8000, 16'h7fff, 16'h8000);
        send_angles(16'hffff, 16'h0001, 16'hffff);
        send_angles(16'd12868, 16'd12869, 16'(-12869));
        send_angles(16'd12868, 16'd12868, 16'd12868);
        send_angles(16'h5555, 16'haaaa, 16'h5555);
        send_angles(16'haaaa, 16'h5555, 16'haaaa);
        send_angles(16'd12868, 16'd0, 16'd12868);
    endtask

    // Random angles, mostly inside +-pi, some anywhere in the raw field.
    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(4) == 0)
                send_angles(16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_angles(rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_quats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Receiver: random stalls, one nonblocking drive per edge.
    always @(posedge clk)
    begin
        if (rst_n) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            quats_seen++;
            if (expected_quats.size() == 0)
            begin
                $display("%0t: unexpected quaternion %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_quats.pop_front();
                if (got.w !== want.w)
                begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
                    errors++;
                end
                if (got.x !== want.x)
                begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
                    errors++;
                end
                if (got.z !== want.z)
                begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transaction on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 32;
        recv_idle_pct = 51;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(130);
        send_idle_pct = 51;
        recv_idle_pct = 32;
        test_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(130);
        wait_drained();
        $display("Checked %0d quaternions from directed and random angle triples,", quats_seen);
        $display("including raw field extremes and fold edges, under varied stalls.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// File: euler_to_quaternion_unit.f
design/e2q_pkg.sv
design/e2q_cordic.sv
design/e2q_combine.sv
design/euler_to_quaternion_unit.sv
design/e2q_checker.sv
test/euler_to_quaternion_unit_tb.sv
